/* design/isml_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isml_pkg
// Shared types and codes for the interval set merge and lookup core.
// ----------------------------------------------------------------------------
package isml_pkg;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_CALC,
        ST_FINISH
    } t_state;

    // Operation codes (carried on tuser)
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_ORDER = 2'd2;

    // Control from the sequencer to the scan datapath
    typedef struct packed {
        logic start;      // clear accumulators for a new item
        logic is_lookup;  // item is a membership lookup
    } t_scan_ctl;

    // Status from the scan datapath back to the sequencer
    typedef struct packed {
        logic busy;       // accumulate stage holds an entry
        logic member;     // lookup found a covering interval
        logic clr_vld;    // entry at the compare stage is absorbed
    } t_scan_sts;

endpackage

/* design/isml_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isml_scan
// Two-stage scan datapath: compares each table entry read from memory with
// the current item, then folds hits into the merged bounds and counters.
// ----------------------------------------------------------------------------
module isml_scan
    import isml_pkg::*;
#(
    parameter int ID_WIDTH = 48,
    parameter int IDX_W    = 6,
    parameter int CNT_W    = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_scan_ctl             i_ctl,
    input  logic [ID_WIDTH-1:0]   i_lo,
    input  logic [ID_WIDTH-1:0]   i_hi,
    input  logic [ID_WIDTH-1:0]   i_id,
    input  logic                  i_rd_vld,      // read data below is live
    input  logic                  i_rd_ent_vld,  // entry holds an interval
    input  logic [IDX_W-1:0]      i_rd_idx,
    input  logic [2*ID_WIDTH-1:0] i_rd_data,     // {end, start}
    output t_scan_sts             o_sts,
    output logic [IDX_W-1:0]      o_clr_idx,
    output logic [ID_WIDTH-1:0]   o_new_lo,
    output logic [ID_WIDTH-1:0]   o_new_hi,
    output logic [ID_WIDTH:0]     o_removed,
    output logic [CNT_W-1:0]      o_hits,
    output logic                  o_free_found,
    output logic [IDX_W-1:0]      o_free_idx
);

    logic [ID_WIDTH-1:0] w_s;
    logic [ID_WIDTH-1:0] w_e;
    logic                w_join;
    logic                w_inrng;
    logic                w_hit;
    logic                w_free;

    logic                r_b_vld;
    logic                r_b_hit;
    logic [ID_WIDTH-1:0] r_b_s;
    logic [ID_WIDTH-1:0] r_b_e;
    logic [ID_WIDTH:0]   r_b_len;

    logic [ID_WIDTH-1:0] r_new_lo;
    logic [ID_WIDTH-1:0] r_new_hi;
    logic [ID_WIDTH:0]   r_removed;
    logic [CNT_W-1:0]    r_hits;
    logic                r_member;
    logic                r_free_found;
    logic [IDX_W-1:0]    r_free_idx;

    // Compare stage: overlap-or-touch test and point test
    assign w_s     = i_rd_data[ID_WIDTH-1:0];
    assign w_e     = i_rd_data[2*ID_WIDTH-1:ID_WIDTH];
    assign w_join  = !({1'b0, w_s} > ({1'b0, i_hi} + 1'b1)) &&
                     !({1'b0, i_lo} > ({1'b0, w_e} + 1'b1));
    assign w_inrng = (w_s <= i_id) && (i_id <= w_e);
    assign w_hit   = i_rd_vld && i_rd_ent_vld && (i_ctl.is_lookup ? w_inrng : w_join);
    assign w_free  = i_rd_vld && !i_ctl.is_lookup && (!i_rd_ent_vld || w_hit);

    // Absorbed entries are released as they pass
    assign o_sts.clr_vld = w_hit && !i_ctl.is_lookup;
    assign o_clr_idx     = i_rd_idx;

    // Compare-to-accumulate pipeline register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_b_hit <= 1'b0;
        end else begin
            r_b_vld <= i_rd_vld;
            r_b_hit <= w_hit;
        end
        r_b_s   <= w_s;
        r_b_e   <= w_e;
        r_b_len <= {1'b0, w_e} - {1'b0, w_s} + 1'b1;
    end

    // First free slot once absorbed entries are gone
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_free_found <= 1'b0;
        end else if (w_free && !r_free_found) begin
            r_free_found <= 1'b1;
        end
        if (w_free && !r_free_found) begin
            r_free_idx <= i_rd_idx;
        end
    end

    // Accumulate stage: merged bounds, removed span, hit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits   <= '0;
            r_member <= 1'b0;
        end else if (i_ctl.start) begin
            r_hits   <= '0;
            r_member <= 1'b0;
        end else if (r_b_vld && r_b_hit) begin
            r_hits   <= r_hits + 1'b1;
            r_member <= 1'b1;
        end
        if (i_ctl.start) begin
            r_new_lo  <= i_lo;
            r_new_hi  <= i_hi;
            r_removed <= '0;
        end else if (r_b_vld && r_b_hit) begin
            if (r_b_s < r_new_lo) begin
                r_new_lo <= r_b_s;
            end
            if (r_b_e > r_new_hi) begin
                r_new_hi <= r_b_e;
            end
            r_removed <= r_removed + r_b_len;
        end
    end

    assign o_sts.busy    = r_b_vld;
    assign o_sts.member  = r_member;
    assign o_new_lo      = r_new_lo;
    assign o_new_hi      = r_new_hi;
    assign o_removed     = r_removed;
    assign o_hits        = r_hits;
    assign o_free_found  = r_free_found;
    assign o_free_idx    = r_free_idx;

endmodule

/* design/interval_set_merge_and_lookup_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_merge_and_lookup_core
// Table of disjoint inclusive ID intervals with merge-on-insert and lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel. tuser carries the operation
//   (insert or lookup); tdata carries range_low, range_high and lookup_id.
//   Each item gives one result item on m_axis: is_member, status, the total
//   of covered IDs and the number of stored intervals.
//   An item walks the whole table, one entry per cycle, through the single
//   read port of the bounds memory, then a compare and an accumulate stage.
//   A result lands in the output register as the block leaves its last step,
//   and the block is ready again in that same cycle. An insert with low
//   above high skips the walk and goes straight to the last step. One item
//   is in work at a time.
//   The output register holds a finished result while the next item is
//   accepted and scanned; if the receiver still stalls when the next result
//   is ready, the block waits in its last step.
//   Reset empties the table at once (valid bits in flip-flops) and clears
//   both counts; the bounds memory itself is not cleared.
// ----------------------------------------------------------------------------
module interval_set_merge_and_lookup_core
    import isml_pkg::*;
#(
    parameter int MAX_RANGES = 64,
    parameter int ID_WIDTH   = 48,
    localparam int IDX_W     = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1,
    localparam int CNT_W     = $clog2(MAX_RANGES + 1),
    localparam int COV_W     = ID_WIDTH + 1,
    localparam int IN_W      = ((3 * ID_WIDTH + 7) / 8) * 8,
    localparam int OUT_RAW   = 3 + COV_W + CNT_W,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: range_low, range_high, lookup_id
    input  logic [IN_W-1:0]  s_axis_tdata,
    // tuser: operation
    input  logic [0:0]       s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // tdata: is_member, status, covered_count, interval_count
    output logic [OUT_W-1:0] m_axis_tdata
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RANGES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_RANGES);

    t_state                r_state;
    t_state                n_state;

    logic                  w_s_fire;
    logic                  w_bad_in;
    logic                  w_rd_en;
    logic                  w_out_free;
    logic                  w_commit;
    t_scan_ctl             w_ctl;
    t_scan_sts             w_sts;
    logic [IDX_W-1:0]      w_clr_idx;
    logic [ID_WIDTH-1:0]   w_new_lo;
    logic [ID_WIDTH-1:0]   w_new_hi;
    logic [ID_WIDTH:0]     w_removed;
    logic [CNT_W-1:0]      w_hits;
    logic                  w_free_found;
    logic [IDX_W-1:0]      w_free_idx;

    logic                  r_op;
    logic                  r_bad_order;
    logic [ID_WIDTH-1:0]   r_lo;
    logic [ID_WIDTH-1:0]   r_hi;
    logic [ID_WIDTH-1:0]   r_id;
    logic [IDX_W-1:0]      r_rd_idx;

    logic [2*ID_WIDTH-1:0] r_mem [MAX_RANGES];
    logic [2*ID_WIDTH-1:0] r_rd_data;
    logic                  r_rd_vld;
    logic                  r_rd_ent_vld;
    logic [IDX_W-1:0]      r_rd_a_idx;
    logic [MAX_RANGES-1:0] r_valid;

    logic [CNT_W-1:0]      r_cnt;
    logic [COV_W-1:0]      r_cov;
    logic [COV_W-1:0]      r_span;
    logic [COV_W-1:0]      r_base;

    logic [CNT_W-1:0]      n_cnt;
    logic [COV_W-1:0]      n_cov;
    logic [1:0]            n_status;
    logic                  n_member;

    logic                  r_out_vld;
    logic                  r_out_member;
    logic [1:0]            r_out_status;
    logic [COV_W-1:0]      r_out_cov;
    logic [CNT_W-1:0]      r_out_cnt;

    assign w_s_fire   = s_axis_tvalid && s_axis_tready;
    assign w_bad_in   = (s_axis_tuser[0] == OP_INSERT) &&
                        (s_axis_tdata[ID_WIDTH-1:0] > s_axis_tdata[2*ID_WIDTH-1:ID_WIDTH]);
    assign w_out_free = !r_out_vld || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_fire) begin
                    n_state = w_bad_in ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_idx == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_vld && !w_sts.busy) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready   = 1'b0;
        w_rd_en         = 1'b0;
        w_ctl.start     = 1'b0;
        w_ctl.is_lookup = (r_op == OP_LOOKUP);
        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
            end
            ST_SCAN: begin
                w_rd_en     = 1'b1;
                w_ctl.start = (r_rd_idx == '0);
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // Result and table update decided in the last step
    always_comb begin
        n_cnt    = r_cnt;
        n_cov    = r_cov;
        n_status = STATUS_OK;
        n_member = 1'b0;
        w_commit = 1'b0;
        if (r_bad_order) begin
            n_status = STATUS_ORDER;
        end else if (r_op == OP_LOOKUP) begin
            n_member = w_sts.member;
        end else if ((w_hits == '0) && (r_cnt == FULL_CNT)) begin
            n_status = STATUS_FULL;
        end else begin
            n_cnt    = r_cnt - w_hits + 1'b1;
            n_cov    = r_base + r_span;
            w_commit = (r_state == ST_FINISH) && w_out_free;
        end
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_idx    <= '0;
            r_op        <= OP_INSERT;
            r_bad_order <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_s_fire) begin
                r_op        <= s_axis_tuser[0];
                r_bad_order <= w_bad_in;
                r_rd_idx    <= '0;
            end else if (w_rd_en) begin
                r_rd_idx <= (r_rd_idx == LAST_IDX) ? '0 : r_rd_idx + 1'b1;
            end
        end
        if (w_s_fire) begin
            r_lo <= s_axis_tdata[ID_WIDTH-1:0];
            r_hi <= s_axis_tdata[2*ID_WIDTH-1:ID_WIDTH];
            r_id <= s_axis_tdata[3*ID_WIDTH-1:2*ID_WIDTH];
        end
    end

    // Bounds memory: one read and one write port, registered read
    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_mem[w_free_idx] <= {w_new_hi, w_new_lo};
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // Read stage tags and entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_valid  <= '0;
        end else begin
            r_rd_vld <= w_rd_en;
            if (w_sts.clr_vld) begin
                r_valid[w_clr_idx] <= 1'b0;
            end
            if (w_commit) begin
                r_valid[w_free_idx] <= 1'b1;
            end
        end
        r_rd_ent_vld <= r_valid[r_rd_idx];
        r_rd_a_idx   <= r_rd_idx;
    end

    // Coverage arithmetic, split over two steps
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_span <= {1'b0, w_new_hi} - {1'b0, w_new_lo} + 1'b1;
            r_base <= r_cov - w_removed;
        end
    end

    // Running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_cov <= '0;
        end else if (w_commit) begin
            r_cnt <= n_cnt;
            r_cov <= n_cov;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if ((r_state == ST_FINISH) && w_out_free) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
        if ((r_state == ST_FINISH) && w_out_free) begin
            r_out_member <= n_member;
            r_out_status <= n_status;
            r_out_cov    <= n_cov;
            r_out_cnt    <= n_cnt;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_out_cnt, r_out_cov, r_out_status, r_out_member});

    isml_scan #(
        .ID_WIDTH (ID_WIDTH),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_lo         (r_lo),
        .i_hi         (r_hi),
        .i_id         (r_id),
        .i_rd_vld     (r_rd_vld),
        .i_rd_ent_vld (r_rd_ent_vld),
        .i_rd_idx     (r_rd_a_idx),
        .i_rd_data    (r_rd_data),
        .o_sts        (w_sts),
        .o_clr_idx    (w_clr_idx),
        .o_new_lo     (w_new_lo),
        .o_new_hi     (w_new_hi),
        .o_removed    (w_removed),
        .o_hits       (w_hits),
        .o_free_found (w_free_found),
        .o_free_idx   (w_free_idx)
    );

`ifndef SYNTH
    // Between items the interval count matches the valid bits
    a_cnt_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt == CNT_W'($countones(r_valid))))
        else $error("interval count differs from valid entries");

    // A stored interval always lands in a free slot found by the scan
    a_commit_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |-> (w_free_found && !r_valid[w_free_idx]))
        else $error("insert writes an occupied or unknown entry");

    // A full rejection only happens with a full table
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (r_out_status == STATUS_FULL)) |-> (r_out_cnt == FULL_CNT))
        else $error("full status with free entries");

    // Count never passes the table depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("interval count above table depth");
`endif

endmodule
